// ===== hdl/sdbf_pkg.sv =====
// shared types, constants and a helper function for the stereo to dac byte ring
package sdbf_pkg;

	localparam int RING_DEPTH = 2048;
	localparam int ROW_COUNT  = RING_DEPTH / 2;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int ROW_W      = $clog2(ROW_COUNT);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int FILL_W     = 12;
	localparam int SAMPLE_W   = 16;
	localparam int VOL_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int ROW_DATA_W = 2 * BYTE_W;
	localparam int PROD_W     = 22;
	localparam int RECIP_W    = 23;
	localparam int RECIP_SH   = 29;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [VOL_W-1:0]   PERCENT_FULL = VOL_W'(100);
	localparam logic [VOL_W-1:0]   VOL_RESET    = VOL_W'(100);
	localparam logic [RECIP_W-1:0] RECIP_100    = RECIP_W'(5368710);
	localparam logic [BYTE_W-1:0]  MIDPOINT     = BYTE_W'(128);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_PULL = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_VOLUME = 1'b0,
		REG_DIFF   = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic              accepted;
		logic              do_write;
		logic              do_read;
		logic              underrun;
		logic              diff;
		logic              rd_hi;
		logic [ROW_W-1:0]  row;
		logic [FILL_W-1:0] fill;
	} ctl_t;

	function automatic logic [BYTE_W-1:0] to_offset_byte(input logic signed [9:0] v);
		logic [BYTE_W-1:0] r;
		if (v < -10'sd128) begin
			r = 8'h00;
		end else if (v > 10'sd127) begin
			r = 8'hFF;
		end else begin
			r = v[7:0] ^ 8'h80;
		end
		return r;
	endfunction

endpackage

// ===== hdl/sdbf_if.sv =====
// request and response channel interfaces
interface sdbf_req_if;
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic signed [15:0]      left_sample;
	logic signed [15:0]      right_sample;

	modport source(output valid, opcode, left_sample, right_sample, input ready);
	modport sink(input valid, opcode, left_sample, right_sample, output ready);
endinterface

interface sdbf_rsp_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [7:0]  dac_byte;
	logic        underrun;
	logic [11:0] fill_level;

	modport source(output valid, accepted, dac_byte, underrun, fill_level, input ready);
	modport sink(input valid, accepted, dac_byte, underrun, fill_level, output ready);
endinterface

// ===== hdl/stereo_to_dac_byte_fifo.sv =====
// top level: ring control, config registers, sample path, ring ram and result register
//
// channel  dir  word
// req      in   opcode, left_sample, right_sample
// rsp      out  accepted, dac_byte, underrun, fill_level
// apb      in   volume_percent at 0, differential_out at 4
//
// one word per cycle sustained while rsp does not stall; every word passes s1, s2, s3 and the result register
// on its way from req to rsp; fill and pointers are decided when the word is taken, the ram is touched three
// stages later, so ram accesses keep word order; push writes one 16-bit row
// all stages move together; a stalled rsp holds the pipeline and req.ready
// arst_n clears pointers, count and stage valids; volume resets to 100, ram is not cleared
module stereo_to_dac_byte_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	sdbf_req_if.sink                         req,
	sdbf_rsp_if.source                       rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sdbf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sdbf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sdbf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	logic [sdbf_pkg::VOL_W-1:0] vol_q;
	logic                       diff_q;
	logic [sdbf_pkg::PTR_W-1:0] rd_ptr_q;
	logic [sdbf_pkg::ROW_W-1:0] wr_row_q;
	logic [sdbf_pkg::CNT_W-1:0] count_q;

	logic                       en;
	logic                       take;
	logic                       is_pull;
	logic [sdbf_pkg::VOL_W-1:0] vol_eff;
	logic                       room;
	logic                       do_push;
	logic                       do_pull;
	logic [sdbf_pkg::CNT_W-1:0] count_nxt;
	logic signed [16:0]         sum;
	logic signed [16:0]         sum_adj;
	logic signed [sdbf_pkg::SAMPLE_W-1:0] mixed;
	sdbf_pkg::ctl_t             ctl_s0;

	logic                        v_s3;
	sdbf_pkg::ctl_t              ctl_s3;
	logic [sdbf_pkg::BYTE_W-1:0] first_s3, second_s3;
	logic                        ram_we, ram_re;
	logic [sdbf_pkg::ROW_DATA_W-1:0] ram_rdata;

	logic                        out_v_q;
	sdbf_pkg::ctl_t              out_ctl_q;

	// apb config
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= sdbf_pkg::VOL_RESET;
			diff_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (sdbf_pkg::reg_sel_t'(paddr[2]))
				sdbf_pkg::REG_VOLUME: vol_q  <= pwdata[sdbf_pkg::VOL_W-1:0];
				sdbf_pkg::REG_DIFF:   diff_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sdbf_pkg::reg_sel_t'(paddr[2]))
			sdbf_pkg::REG_VOLUME: prdata = sdbf_pkg::APB_DATA_W'(vol_q);
			sdbf_pkg::REG_DIFF:   prdata = sdbf_pkg::APB_DATA_W'(diff_q);
			default:              prdata = '0;
		endcase
	end

	// word admission and ring bookkeeping
	assign en        = !out_v_q || rsp.ready;
	assign req.ready = en;
	assign take      = req.valid && en;

	always_comb begin
		is_pull   = (sdbf_pkg::opcode_t'(req.opcode) == sdbf_pkg::OP_PULL);
		vol_eff   = (vol_q > sdbf_pkg::PERCENT_FULL) ? sdbf_pkg::PERCENT_FULL : vol_q;
		room      = count_q <= sdbf_pkg::CNT_W'(sdbf_pkg::RING_DEPTH - 2);
		do_push   = !is_pull && (vol_eff != '0) && room;
		do_pull   = is_pull && (count_q != '0);
		count_nxt = count_q;
		if (do_push) begin
			count_nxt = count_q + sdbf_pkg::CNT_W'(2);
		end else if (do_pull) begin
			count_nxt = count_q - sdbf_pkg::CNT_W'(1);
		end
		sum     = 17'(req.left_sample) + 17'(req.right_sample);
		sum_adj = sum + 17'($unsigned(sum[16]));
		mixed   = sum_adj[16:1];

		ctl_s0.accepted = is_pull || (vol_eff == '0) || room;
		ctl_s0.do_write = do_push;
		ctl_s0.do_read  = do_pull;
		ctl_s0.underrun = is_pull && (count_q == '0);
		ctl_s0.diff     = diff_q;
		ctl_s0.rd_hi    = rd_ptr_q[0];
		ctl_s0.row      = is_pull ? rd_ptr_q[sdbf_pkg::PTR_W-1:1] : wr_row_q;
		ctl_s0.fill     = sdbf_pkg::FILL_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_row_q <= '0;
			count_q  <= '0;
		end else if (take) begin
			count_q <= count_nxt;
			if (do_push) begin
				wr_row_q <= (wr_row_q == sdbf_pkg::ROW_W'(sdbf_pkg::ROW_COUNT - 1))
				            ? '0 : wr_row_q + 1'b1;
			end
			if (do_pull) begin
				rd_ptr_q <= (rd_ptr_q == sdbf_pkg::PTR_W'(sdbf_pkg::RING_DEPTH - 1))
				            ? '0 : rd_ptr_q + 1'b1;
			end
		end
	end

	sdbf_sample_path u_path (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (take),
		.in_ctl     (ctl_s0),
		.in_mixed   (mixed),
		.in_vol     (vol_eff),
		.out_valid  (v_s3),
		.out_ctl    (ctl_s3),
		.out_first  (first_s3),
		.out_second (second_s3)
	);

	assign ram_we = en && v_s3 && ctl_s3.do_write;
	assign ram_re = en && v_s3 && ctl_s3.do_read;

	sdbf_ring_ram #(
		.DEPTH (sdbf_pkg::ROW_COUNT),
		.WIDTH (sdbf_pkg::ROW_DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctl_s3.row),
		.wdata ({second_s3, first_s3}),
		.re    (ram_re),
		.raddr (ctl_s3.row),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctl_q <= ctl_s3;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.accepted   = out_ctl_q.accepted;
	assign rsp.underrun   = out_ctl_q.underrun;
	assign rsp.fill_level = out_ctl_q.fill;

	always_comb begin
		if (out_ctl_q.do_read) begin
			rsp.dac_byte = out_ctl_q.rd_hi ? ram_rdata[15:8] : ram_rdata[7:0];
		end else if (out_ctl_q.underrun) begin
			rsp.dac_byte = sdbf_pkg::MIDPOINT;
		end else begin
			rsp.dac_byte = '0;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sdbf_pkg::CNT_W'(sdbf_pkg::RING_DEPTH))
		else $error("ring count above depth");

	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ram read and write in one cycle");

	a_underrun_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.underrun) |-> (rsp.dac_byte == sdbf_pkg::MIDPOINT && rsp.accepted
		&& rsp.fill_level == '0))
		else $error("underrun word malformed");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !ctl_s0.accepted) |=> $stable(count_q))
		else $error("rejected push changed the count");
`endif

endmodule

// ===== hdl/sdbf_ring_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
module sdbf_ring_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/sdbf_sample_path.sv =====
// three stage scale path: gain multiply, divide by 100, shift and clamp to bytes
module sdbf_sample_path (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  sdbf_pkg::ctl_t                       in_ctl,
	input  logic signed [sdbf_pkg::SAMPLE_W-1:0] in_mixed,
	input  logic [sdbf_pkg::VOL_W-1:0]           in_vol,
	output logic                                 out_valid,
	output sdbf_pkg::ctl_t                       out_ctl,
	output logic [sdbf_pkg::BYTE_W-1:0]          out_first,
	output logic [sdbf_pkg::BYTE_W-1:0]          out_second
);

	logic                                 v_s1, v_s2, v_s3;
	sdbf_pkg::ctl_t                       ctl_s1, ctl_s2, ctl_s3;
	logic signed [sdbf_pkg::SAMPLE_W-1:0] mixed_s1;
	logic [sdbf_pkg::VOL_W-1:0]           vol_s1;
	logic [sdbf_pkg::PROD_W-1:0]          prod_s2;
	logic                                 neg_s2, neg_s3;
	logic [sdbf_pkg::SAMPLE_W-1:0]        quo_s3;

	logic [sdbf_pkg::SAMPLE_W-1:0] mag;
	logic [sdbf_pkg::SAMPLE_W+sdbf_pkg::VOL_W-1:0] prod;
	logic [sdbf_pkg::PROD_W+sdbf_pkg::RECIP_W-1:0] recip_prod;
	logic signed [16:0]            scaled;
	logic signed [9:0]             s8;
	logic signed [9:0]             s8_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// gain multiply on the magnitude
	always_comb begin
		mag  = mixed_s1[sdbf_pkg::SAMPLE_W-1] ? sdbf_pkg::SAMPLE_W'(~mixed_s1 + 1'b1)
		                                      : sdbf_pkg::SAMPLE_W'(mixed_s1);
		prod = mag * vol_s1;
	end

	// divide by 100 through the reciprocal
	assign recip_prod = prod_s2 * sdbf_pkg::RECIP_100;

	always_comb begin
		scaled = neg_s3 ? -$signed({1'b0, quo_s3}) : $signed({1'b0, quo_s3});
		s8     = 10'(scaled >>> 8);
		s8_neg = -s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1   <= in_ctl;
			mixed_s1 <= in_mixed;
			vol_s1   <= in_vol;
			ctl_s2   <= ctl_s1;
			prod_s2  <= prod[sdbf_pkg::PROD_W-1:0];
			neg_s2   <= mixed_s1[sdbf_pkg::SAMPLE_W-1];
			ctl_s3   <= ctl_s2;
			quo_s3   <= recip_prod[sdbf_pkg::RECIP_SH +: sdbf_pkg::SAMPLE_W];
			neg_s3   <= neg_s2;
		end
	end

	assign out_valid  = v_s3;
	assign out_ctl    = ctl_s3;
	assign out_first  = sdbf_pkg::to_offset_byte(s8);
	assign out_second = ctl_s3.diff ? sdbf_pkg::to_offset_byte(s8_neg)
	                                : sdbf_pkg::to_offset_byte(s8);

endmodule

// ===== tb/stereo_to_dac_byte_fifo_tb.sv =====
// testbench for the stereo to dac byte ring: predicted results checked under random traffic and stalls
module stereo_to_dac_byte_fifo_tb;

	localparam int FULL_SCALE = 100;
	localparam int LEVEL_MIN  = -128;
	localparam int LEVEL_MAX  = 127;
	localparam logic [sdbf_pkg::APB_ADDR_W-1:0] ADDR_VOLUME =
		sdbf_pkg::APB_ADDR_W'(4 * sdbf_pkg::REG_VOLUME);
	localparam logic [sdbf_pkg::APB_ADDR_W-1:0] ADDR_DIFF   =
		sdbf_pkg::APB_ADDR_W'(4 * sdbf_pkg::REG_DIFF);

	typedef struct {
		logic        accepted;
		logic [7:0]  dac_byte;
		logic        underrun;
		logic [11:0] fill_level;
	} ring_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [sdbf_pkg::APB_ADDR_W-1:0] paddr;
	logic [sdbf_pkg::APB_DATA_W-1:0] pwdata;
	logic [sdbf_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	sdbf_req_if req_ch();
	sdbf_rsp_if rsp_ch();

	stereo_to_dac_byte_fifo i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	// byte ring as the block should hold it
	logic [7:0]   ring_mem [sdbf_pkg::RING_DEPTH];
	int           rd_ptr = 0;
	int           wr_ptr = 0;
	int           ring_fill = 0;
	logic [6:0]   vol_reg = sdbf_pkg::VOL_RESET;
	logic         diff_reg = 1'b0;
	ring_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int send_calm = 0;
	int recv_calm = 0;

	int error_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int pushes_refused = 0;
	int underrun_pulls = 0;
	int peak_fill = 0;
	int settings_used = 0;

	function automatic logic [7:0] clamp_offset(input int level);
		if (level < LEVEL_MIN) begin
			return 8'h00;
		end else if (level > LEVEL_MAX) begin
			return 8'hFF;
		end
		return 8'(level + 128);
	endfunction

	function automatic ring_result_t step_ring_model(input sdbf_pkg::opcode_t op,
			input logic signed [15:0] left_s, input logic signed [15:0] right_s);
		ring_result_t res;
		int           vol;
		int           mean;
		int           scaled;
		int           level;
		logic [7:0]   first;
		logic [7:0]   second;
		res.accepted = 1'b1;
		res.dac_byte = 8'h00;
		res.underrun = 1'b0;
		if (op == sdbf_pkg::OP_PUSH) begin
			vol = (int'(vol_reg) > FULL_SCALE) ? FULL_SCALE : int'(vol_reg);
			if (vol != 0) begin
				if (sdbf_pkg::RING_DEPTH - ring_fill >= 2) begin
					mean = (int'(left_s) + int'(right_s)) / 2;
					scaled = (mean * vol) / FULL_SCALE;
					level = scaled >>> 8;
					first = clamp_offset(level);
					second = diff_reg ? clamp_offset(-level) : first;
					ring_mem[wr_ptr] = first;
					wr_ptr = (wr_ptr + 1) % sdbf_pkg::RING_DEPTH;
					ring_mem[wr_ptr] = second;
					wr_ptr = (wr_ptr + 1) % sdbf_pkg::RING_DEPTH;
					ring_fill += 2;
				end else begin
					res.accepted = 1'b0;
				end
			end
		end else begin
			if (ring_fill > 0) begin
				res.dac_byte = ring_mem[rd_ptr];
				rd_ptr = (rd_ptr + 1) % sdbf_pkg::RING_DEPTH;
				ring_fill -= 1;
			end else begin
				res.dac_byte = sdbf_pkg::MIDPOINT;
				res.underrun = 1'b1;
			end
		end
		res.fill_level = 12'(ring_fill);
		return res;
	endfunction

	function automatic bit take_break(input int pct, inout int calm);
		if (calm > 0) begin
			calm--;
			return 1'b0;
		end
		if ($urandom_range(0, 63) == 0) begin
			calm = $urandom_range(8, 40);
			return 1'b0;
		end
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic signed [15:0] random_sample();
		logic [15:0] corners [4];
		corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
		case ($urandom_range(0, 3))
			0: begin
				return corners[$urandom_range(0, 3)];
			end
			1: begin
				return 16'(int'($urandom_range(0, 1200)) - 600);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	task automatic check_result();
		ring_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("word with nothing pending, fill_level %0d",
				rsp_ch.fill_level));
		end else begin
			want = pending_results.pop_front();
			compare_field("accepted", rsp_ch.accepted, want.accepted);
			compare_field("dac_byte", rsp_ch.dac_byte, want.dac_byte);
			compare_field("underrun", rsp_ch.underrun, want.underrun);
			compare_field("fill_level", rsp_ch.fill_level, want.fill_level);
			words_checked++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			check_result();
		end
		rsp_ch.ready <= !take_break(recv_stall_pct, recv_calm);
	end

	task automatic send_word(input sdbf_pkg::opcode_t op, input logic signed [15:0] left_s,
			input logic signed [15:0] right_s);
		ring_result_t res;
		while (take_break(send_idle_pct, send_calm)) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.left_sample <= left_s;
		req_ch.right_sample <= right_s;
		do @(posedge clk); while (!req_ch.ready);
		res = step_ring_model(op, left_s, right_s);
		pending_results.push_back(res);
		words_sent++;
		if (!res.accepted) pushes_refused++;
		if (res.underrun) underrun_pulls++;
		if (ring_fill > peak_fill) peak_fill = ring_fill;
	endtask

	task automatic send_random(input int push_pct);
		sdbf_pkg::opcode_t op;
		op = ($urandom_range(0, 99) < push_pct) ? sdbf_pkg::OP_PUSH : sdbf_pkg::OP_PULL;
		send_word(op, random_sample(), random_sample());
	endtask

	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic apb_access(input logic wr, input logic [sdbf_pkg::APB_ADDR_W-1:0] addr,
			input logic [sdbf_pkg::APB_DATA_W-1:0] data,
			output logic [sdbf_pkg::APB_DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int vol, input int diff);
		logic [sdbf_pkg::APB_DATA_W-1:0] rd;
		wait_all_results();
		repeat (8) @(posedge clk);
		apb_access(1'b1, ADDR_VOLUME, sdbf_pkg::APB_DATA_W'(vol), rd);
		apb_access(1'b1, ADDR_DIFF, sdbf_pkg::APB_DATA_W'(diff), rd);
		vol_reg = 7'(vol);
		diff_reg = 1'(diff);
		apb_access(1'b0, ADDR_VOLUME, '0, rd);
		compare_field("volume_percent readback", rd, sdbf_pkg::APB_DATA_W'(vol_reg));
		apb_access(1'b0, ADDR_DIFF, '0, rd);
		compare_field("differential_out readback", rd, sdbf_pkg::APB_DATA_W'(diff_reg));
		settings_used++;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic test_empty_pull();
		send_word(sdbf_pkg::OP_PULL, 16'h7FFF, 16'h8000);
		send_word(sdbf_pkg::OP_PULL, 16'h0000, 16'hFFFF);
	endtask

	// full scale corners, negation of the lowest level, mute and gain above full
	task automatic test_extremes();
		set_config(127, 1);
		send_word(sdbf_pkg::OP_PUSH, -32768, -32768);
		send_word(sdbf_pkg::OP_PUSH, 32767, 32767);
		send_word(sdbf_pkg::OP_PUSH, -1, -2);
		set_config(0, 0);
		send_word(sdbf_pkg::OP_PUSH, 1234, -77);
		set_config(1, 0);
		send_word(sdbf_pkg::OP_PUSH, 32767, 32767);
		send_word(sdbf_pkg::OP_PUSH, -32768, -32767);
		repeat (11) send_word(sdbf_pkg::OP_PULL, 0, -1);
	endtask

	task automatic test_mixed_settings();
		int vols [6];
		int diffs [6];
		vols = '{100, 50, 127, 0, 1, 73};
		diffs = '{0, 1, 1, 0, 1, 0};
		for (int i = 0; i < 6; i++) begin
			set_config(vols[i], diffs[i]);
			repeat (50) send_random(50);
		end
	endtask

	task automatic test_fill_to_full();
		bit paused;
		paused = 1'b0;
		set_config($urandom_range(1, 127), $urandom_range(0, 1));
		while (ring_fill < sdbf_pkg::RING_DEPTH - 1) begin
			send_random(90);
			if (!paused && ring_fill >= sdbf_pkg::RING_DEPTH / 2) begin
				wait_all_results();
				paused = 1'b1;
			end
		end
		// hover near full so pushes get refused
		repeat (150) send_random(40);
	endtask

	task automatic test_drain();
		set_config(64, 1);
		repeat (200) send_random(20);
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= sdbf_pkg::OP_PULL;
		req_ch.left_sample <= '0;
		req_ch.right_sample <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(23, 53);
		test_empty_pull();
		test_extremes();
		test_mixed_settings();
		set_idling(53, 23);
		test_fill_to_full();
		set_idling(0, 0);
		test_drain();
		wait_all_results();
		repeat (12) @(posedge clk);
		$display("covered %0d words (%0d checked) over %0d register settings", words_sent,
			words_checked, settings_used);
		$display("%0d pushes refused on a full ring, %0d empty pulls, peak fill %0d bytes",
			pushes_refused, underrun_pulls, peak_fill);
		if (error_count == 0) begin
			$display("stereo_to_dac_byte_fifo test passed");
		end else begin
			$display("stereo_to_dac_byte_fifo test failed");
		end
		$finish;
	end

	initial begin
		#4_800_000;
		$display("run did not finish in time, %0d words still pending", pending_results.size());
		$display("stereo_to_dac_byte_fifo test failed");
		$finish;
	end

endmodule
